>>> design/fir_filter_512_tap_core_macros.svh
// assertion macros shared by the fir filter controller and datapath
// no dependencies; included by the modules that carry assertions
`ifndef FIR_FILTER_512_TAP_CORE_MACROS_SVH
`define FIR_FILTER_512_TAP_CORE_MACROS_SVH

// property must hold at every edge outside reset
`define FIR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define FIR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/fir512_pkg.sv
// shared types and constants of the fir filter core
// no dependencies; used by controller, datapath and top level
package fir512_pkg;

   localparam int IDX_BITS = 9;
   localparam int LEN_BITS = 10;
   localparam logic [LEN_BITS-1:0] LEN_RESET = 10'd512;

   localparam logic KIND_SAMPLE   = 1'b0;
   localparam logic KIND_LOAD_TAP = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_DRAIN
   } fir512_state_type;

   typedef struct packed {
      logic clear_wr;
      logic load_tap;
      logic load_sample;
      logic issue;
      logic finish;
   } fir512_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic rsp_free;
   } fir512_status_type;

endpackage

>>> design/fir512_ctrl.sv
// controller of the fir filter core: clear pass, item accept and tap sequencing
// depends on fir512_pkg and fir_filter_512_tap_core_macros.svh
`include "fir_filter_512_tap_core_macros.svh"

module fir512_ctrl #(
   parameter int TAP_COUNT = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_kind,
   output logic                          req_ready,
   input  logic [$clog2(TAP_COUNT+1)-1:0] used_count,
   input  fir512_pkg::fir512_status_type status,
   output fir512_pkg::fir512_cmd_type    cmd,
   output logic [$clog2(TAP_COUNT)-1:0]  addr
);

   localparam int AW = $clog2(TAP_COUNT);
   localparam int KW = $clog2(TAP_COUNT + 1);

   fir512_pkg::fir512_state_type state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fir512_pkg::ST_CLEAR;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         fir512_pkg::ST_CLEAR: begin
            // one entry of each memory zeroed per cycle
            cmd.clear_wr = 1'b1;
            if (k_ff == KW'(TAP_COUNT - 1)) begin
               k_in     = '0;
               state_in = fir512_pkg::ST_IDLE;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         fir512_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == fir512_pkg::KIND_LOAD_TAP) begin
                  cmd.load_tap = 1'b1;
               end else begin
                  cmd.load_sample = 1'b1;
                  k_in            = '0;
                  state_in        = fir512_pkg::ST_MAC;
               end
            end
         end
         fir512_pkg::ST_MAC: begin
            if (k_ff < used_count) begin
               cmd.issue = 1'b1;
               k_in      = k_ff + KW'(1);
            end else begin
               state_in = fir512_pkg::ST_DRAIN;
            end
         end
         fir512_pkg::ST_DRAIN: begin
            if (!status.pipe_busy && status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = fir512_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fir512_pkg::ST_IDLE;
         end
      endcase
   end

   assign addr = k_ff[AW-1:0];

   `FIR_ASSERT_IMPL(a_tap_count_bound, clock, reset, state_ff == fir512_pkg::ST_MAC, k_ff <= used_count, "tap counter ran past length")
   `FIR_ASSERT_NEXT(a_sample_starts_mac, clock, reset, cmd.load_sample, (state_ff == fir512_pkg::ST_MAC) && (k_ff == '0), "sample did not start at tap zero")
   `FIR_ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != fir512_pkg::ST_IDLE, !req_ready, "word accepted while busy")

endmodule

>>> design/fir512_dp.sv
// datapath of the fir filter core: tap and history memories, mac pipeline, rounding,
// saturation, length and result registers; depends on fir512_pkg and the macros header
`include "fir_filter_512_tap_core_macros.svh"

module fir512_dp #(
   parameter int TAP_COUNT   = 512,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fir512_pkg::fir512_cmd_type           cmd,
   output fir512_pkg::fir512_status_type        status,
   input  logic [$clog2(TAP_COUNT)-1:0]         addr,
   output logic [$clog2(TAP_COUNT+1)-1:0]       used_count,
   input  logic                                 csr_valid,
   input  logic [fir512_pkg::LEN_BITS-1:0]      csr_data,
   input  logic [fir512_pkg::IDX_BITS-1:0]      req_tap_index,
   input  logic signed [SAMPLE_BITS-1:0]        req_value,
   input  logic                                 req_end_of_block,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [SAMPLE_BITS-1:0]               rsp_sample,
   output logic                                 rsp_block_end
);

   localparam int AW    = $clog2(TAP_COUNT);
   localparam int KW    = $clog2(TAP_COUNT + 1);
   localparam int PW    = 2 * SAMPLE_BITS;
   localparam int ACC_W = PW + $clog2(TAP_COUNT) + 1;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (SAMPLE_BITS - 2);

   logic signed [SAMPLE_BITS-1:0] tap_mem  [TAP_COUNT];
   logic signed [SAMPLE_BITS-1:0] hist_mem [TAP_COUNT];

   logic [fir512_pkg::LEN_BITS-1:0] tap_length_ff, tap_length_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic rd_valid_ff, rd_valid_in;
   logic prod_valid_ff, prod_valid_in;
   logic signed [SAMPLE_BITS-1:0] tap_rd_ff, hist_rd_ff;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic eob_ff, eob_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_last_ff, rsp_last_in;

   logic [31:0] len_wide;
   logic tap_idx_ok;
   logic [AW-1:0] tap_addr;
   logic signed [ACC_W-1:0] rounded, shifted;
   logic fits;
   logic [SAMPLE_BITS-1:0] sat_out;

   // tap length above the store size means every tap
   assign len_wide   = 32'(tap_length_ff);
   assign used_count = (len_wide >= 32'(TAP_COUNT)) ? KW'(TAP_COUNT) : KW'(len_wide);

   assign tap_idx_ok = 32'(req_tap_index) < 32'(TAP_COUNT);
   assign tap_addr   = AW'(32'(req_tap_index));

   // memory write ports
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         tap_mem[addr] <= '0;
      end else if (cmd.load_tap && tap_idx_ok) begin
         tap_mem[tap_addr] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         hist_mem[addr] <= '0;
      end else if (cmd.load_sample) begin
         hist_mem[ptr_ff] <= req_value;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         tap_rd_ff  <= tap_mem[addr];
         hist_rd_ff <= hist_mem[slot_ff];
      end
   end

   always_comb begin
      tap_length_in = csr_valid ? csr_data : tap_length_ff;

      ptr_in  = ptr_ff;
      slot_in = slot_ff;
      eob_in  = eob_ff;
      if (cmd.load_sample) begin
         slot_in = ptr_ff;
         ptr_in  = (ptr_ff == AW'(TAP_COUNT - 1)) ? '0 : ptr_ff + AW'(1);
         eob_in  = req_end_of_block;
      end else if (cmd.issue) begin
         // walk back through the history ring
         slot_in = (slot_ff == '0) ? AW'(TAP_COUNT - 1) : slot_ff - AW'(1);
      end

      rd_valid_in   = cmd.issue;
      prod_valid_in = rd_valid_ff;
      prod_in       = tap_rd_ff * hist_rd_ff;

      if (cmd.load_sample) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   // round half up, then saturate
   always_comb begin
      rounded = acc_ff + ROUND_HALF;
      shifted = rounded >>> (SAMPLE_BITS - 1);
      fits    = (&shifted[ACC_W-1:SAMPLE_BITS-1]) | ~(|shifted[ACC_W-1:SAMPLE_BITS-1]);
      if (fits) begin
         sat_out = shifted[SAMPLE_BITS-1:0];
      end else if (shifted[ACC_W-1]) begin
         sat_out = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         sat_out = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = sat_out;
         rsp_last_in  = eob_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_length_ff <= fir512_pkg::LEN_RESET;
         ptr_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tap_length_ff <= tap_length_in;
         ptr_ff        <= ptr_in;
         rd_valid_ff   <= rd_valid_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      eob_ff      <= eob_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.pipe_busy = rd_valid_ff | prod_valid_ff;
   assign status.rsp_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sample    = rsp_data_ff;
   assign rsp_block_end = rsp_last_ff;

   `FIR_ASSERT(a_no_issue_in_clear, clock, reset, !(cmd.issue && cmd.clear_wr), "read issued during clear pass")
   `FIR_ASSERT_NEXT(a_acc_cleared, clock, reset, cmd.load_sample, acc_ff == '0, "accumulator not cleared for new sample")
   `FIR_ASSERT_IMPL(a_tap_load_quiet, clock, reset, cmd.load_tap, !rd_valid_ff && !prod_valid_ff, "tap written during mac")

endmodule

>>> design/fir_filter_512_tap_core.sv
// direct-form fir core: one shared multiply-accumulate walks the taps, one tap per cycle.
// a sample word runs its used taps through the read, product and accumulate registers, then its
// rounded, saturated result is registered; used = min(tap_length, TAP_COUNT). the next word is
// accepted only once that result is registered, not while the last sample is in flight; a held
// result adds its wait. a tap load word gives no result; synchronous reset starts a clearing pass
// of tap and history memories with no word accepted; tap_length resets to 512.
module fir_filter_512_tap_core #(
   parameter int TAP_COUNT   = 512,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // fields from bit 0: tap_index[8:0], value
   input  logic [((fir512_pkg::IDX_BITS+SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // kind
   input  logic                                  req_tuser,
   input  logic                                  req_tlast,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // fields from bit 0: filtered_sample
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]      rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [fir512_pkg::LEN_BITS-1:0]       csr_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready
);

   localparam int AW    = $clog2(TAP_COUNT);
   localparam int KW    = $clog2(TAP_COUNT + 1);
   localparam int RSP_W = ((SAMPLE_BITS + 7) / 8) * 8;

   fir512_pkg::fir512_cmd_type    cmd;
   fir512_pkg::fir512_status_type status;
   logic [AW-1:0]          addr;
   logic [KW-1:0]          used_count;
   logic                   req_ready_int;
   logic [SAMPLE_BITS-1:0] rsp_sample;

   assign csr_ready  = 1'b1;
   assign req_tready = req_ready_int;
   assign rsp_tdata  = RSP_W'(rsp_sample);

   fir512_ctrl #(
      .TAP_COUNT (TAP_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_kind   (req_tuser),
      .req_ready  (req_ready_int),
      .used_count (used_count),
      .status     (status),
      .cmd        (cmd),
      .addr       (addr)
   );

   fir512_dp #(
      .TAP_COUNT   (TAP_COUNT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .addr             (addr),
      .used_count       (used_count),
      .csr_valid        (csr_valid),
      .csr_data         (csr_data),
      .req_tap_index    (req_tdata[fir512_pkg::IDX_BITS-1:0]),
      .req_value        ($signed(req_tdata[fir512_pkg::IDX_BITS +: SAMPLE_BITS])),
      .req_end_of_block (req_tlast),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_sample       (rsp_sample),
      .rsp_block_end    (rsp_tlast)
   );

endmodule
